[hdl/mpsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsc_pkg
// shared types and constants of the multichannel pid speed control core
// ----------------------------------------------------------------------------
package mpsc_pkg;

	localparam int CHANNELS_DEF     = 8;
	localparam int INTEGRAL_W_DEF   = 32;

	localparam int CHAN_W           = 3;
	localparam int RPM_W            = 16;
	localparam int ERR_W            = 17;
	localparam int DRIVE_W          = 16;
	localparam int GAIN_W           = 16;
	localparam int LIMIT_W          = 15;
	localparam int FRAC_W           = 8;
	localparam int CFG_IDX_W        = 3;
	localparam int CFG_DATA_W       = 16;
	localparam int DERIV_TAP_WEIGHT = 2;

	localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd256;
	localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 16'd77;
	localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 16'd0;
	localparam logic [LIMIT_W-1:0] DRIVE_LIMIT_RST = 15'd5000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_DRIVE_LIMIT = 3'd3,
		REG_LAW_MODE    = 3'd4
	} cfg_reg_t;

	typedef enum logic {
		LAW_POSITIONAL  = 1'b0,
		LAW_INCREMENTAL = 1'b1
	} law_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_MUL,
		ST_SUM,
		ST_FIN
	} pid_state_t;

	typedef struct packed {
		logic load;
		logic calc;
		logic mul;
		logic sum;
	} dp_ctrl_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  prop_gain;
		logic [GAIN_W-1:0]  integ_gain;
		logic [GAIN_W-1:0]  deriv_gain;
		logic [LIMIT_W-1:0] drive_limit;
		law_t               law_mode;
	} pid_cfg_t;

endpackage

[hdl/mpsc_state_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsc_state_mem
// per-channel state memory, one write and one registered read port,
// entries never written since reset read as zero
// ----------------------------------------------------------------------------
module mpsc_state_mem #(
	parameter int DEPTH  = 8,
	parameter int WORD_W = 82
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WORD_W-1:0]                    rdata,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WORD_W-1:0]                    wdata
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  valid_q;
	logic [WORD_W-1:0] rdata_q;
	logic              rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvalid_q <= valid_q[raddr];
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

[hdl/mpsc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpsc_datapath
// error, operand selection, gain products, q42.8 sum (default integral width), clamp and truncation
// ----------------------------------------------------------------------------
module mpsc_datapath import mpsc_pkg::*; #(
	parameter int INTEGRAL_W = INTEGRAL_W_DEF
) (
	input  logic                                  clk,
	input  dp_ctrl_t                              ctrl,
	input  pid_cfg_t                              cfg,
	input  logic signed [RPM_W-1:0]               target_rpm,
	input  logic signed [RPM_W-1:0]               measured_rpm,
	input  logic [INTEGRAL_W+2*ERR_W+DRIVE_W-1:0] rd_word,
	output logic [INTEGRAL_W+2*ERR_W+DRIVE_W-1:0] wr_word,
	output logic signed [DRIVE_W-1:0]             drive_fin
);

	localparam int IW     = INTEGRAL_W;
	localparam int WORD_W = IW + 2 * ERR_W + DRIVE_W;
	localparam int PA_W   = ERR_W + 1;
	localparam int PC_W   = ERR_W + 2;
	localparam int KS_W   = GAIN_W + 1;
	localparam int LO_W   = IW / 2;
	localparam int HI_W   = IW - LO_W;
	localparam int SW     = IW + 18;
	localparam int Q_W    = LIMIT_W + FRAC_W + 1;
	localparam logic signed [2:0] TAP_W = 3'(DERIV_TAP_WEIGHT);
	localparam logic signed [IW-1:0] IMAX = {1'b0, {(IW-1){1'b1}}};
	localparam logic signed [IW-1:0] IMIN = {1'b1, {(IW-1){1'b0}}};

	logic signed [ERR_W-1:0]   err_in;
	logic signed [ERR_W-1:0]   e_s1;

	logic signed [IW-1:0]      rd_integ;
	logic signed [ERR_W-1:0]   rd_last;
	logic signed [ERR_W-1:0]   rd_older;
	logic signed [DRIVE_W-1:0] rd_drive;
	logic signed [IW:0]        integ_sum;
	logic signed [IW-1:0]      integ_sat;
	logic signed [PA_W-1:0]    diff1;
	logic signed [PC_W-1:0]    diff2;

	logic signed [PA_W-1:0]    pa_s2;
	logic signed [IW-1:0]      pb_s2;
	logic signed [PC_W-1:0]    pc_s2;
	logic signed [DRIVE_W-1:0] base_s2;
	logic signed [IW-1:0]      integ_s2;
	logic signed [ERR_W-1:0]   older_s2;

	logic signed [KS_W-1:0]         kp_s;
	logic signed [KS_W-1:0]         ki_s;
	logic signed [KS_W-1:0]         kd_s;
	logic signed [LO_W:0]           pb_lo;
	logic signed [HI_W-1:0]         pb_hi;
	logic signed [KS_W+PA_W-1:0]    prod_p_s3;
	logic signed [KS_W+LO_W:0]      prod_lo_s3;
	logic signed [KS_W+HI_W-1:0]    prod_hi_s3;
	logic signed [KS_W+PC_W-1:0]    prod_d_s3;
	logic signed [DRIVE_W-1:0]      base_s3;

	logic signed [SW-1:0]      sum_s4;
	logic signed [SW-1:0]      lim;
	logic signed [SW-1:0]      clamped;
	logic signed [Q_W-1:0]     q_clamp;
	logic signed [Q_W-1:0]     q_round;

	assign err_in = $signed({target_rpm[RPM_W-1], target_rpm})
		- $signed({measured_rpm[RPM_W-1], measured_rpm});

	assign rd_integ = $signed(rd_word[WORD_W-1 -: IW]);
	assign rd_last  = $signed(rd_word[2*ERR_W+DRIVE_W-1 -: ERR_W]);
	assign rd_older = $signed(rd_word[ERR_W+DRIVE_W-1 -: ERR_W]);
	assign rd_drive = $signed(rd_word[DRIVE_W-1:0]);

	// saturating integral
	always_comb begin
		integ_sum = $signed({rd_integ[IW-1], rd_integ})
			+ $signed({{(IW+1-ERR_W){e_s1[ERR_W-1]}}, e_s1});
		if (integ_sum[IW] != integ_sum[IW-1]) begin
			integ_sat = integ_sum[IW] ? IMIN : IMAX;
		end else begin
			integ_sat = integ_sum[IW-1:0];
		end
	end

	always_comb begin
		logic signed [PC_W-1:0] e_w;
		logic signed [PC_W-1:0] last_w;
		logic signed [PC_W-1:0] older_w;
		e_w     = PC_W'(e_s1);
		last_w  = PC_W'(rd_last);
		older_w = PC_W'(rd_older);
		diff1   = PA_W'(e_s1) - PA_W'(rd_last);
		diff2   = e_w - PC_W'(TAP_W * last_w) + older_w;
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			e_s1 <= err_in;
		end
		if (ctrl.calc) begin
			if (cfg.law_mode == LAW_INCREMENTAL) begin
				pa_s2    <= diff1;
				pb_s2    <= IW'(e_s1);
				pc_s2    <= diff2;
				base_s2  <= rd_drive;
				integ_s2 <= rd_integ;
				older_s2 <= rd_last;
			end else begin
				pa_s2    <= PA_W'(e_s1);
				pb_s2    <= integ_sat;
				pc_s2    <= PC_W'(diff1);
				base_s2  <= '0;
				integ_s2 <= integ_sat;
				older_s2 <= rd_older;
			end
		end
	end

	assign kp_s  = $signed({1'b0, cfg.prop_gain});
	assign ki_s  = $signed({1'b0, cfg.integ_gain});
	assign kd_s  = $signed({1'b0, cfg.deriv_gain});
	assign pb_lo = $signed({1'b0, pb_s2[LO_W-1:0]});
	assign pb_hi = $signed(pb_s2[IW-1:LO_W]);

	always_ff @(posedge clk) begin
		if (ctrl.mul) begin
			prod_p_s3  <= kp_s * pa_s2;
			prod_lo_s3 <= ki_s * pb_lo;
			prod_hi_s3 <= ki_s * pb_hi;
			prod_d_s3  <= kd_s * pc_s2;
			base_s3    <= base_s2;
		end
		if (ctrl.sum) begin
			sum_s4 <= SW'(prod_p_s3) + SW'(prod_lo_s3) + (SW'(prod_hi_s3) <<< LO_W)
				+ SW'(prod_d_s3) + (SW'(base_s3) <<< FRAC_W);
		end
	end

	// clamp to the limit, then truncate toward zero
	always_comb begin
		lim = $signed({{(SW-LIMIT_W-FRAC_W){1'b0}}, cfg.drive_limit, {FRAC_W{1'b0}}});
		if (sum_s4 > lim) begin
			clamped = lim;
		end else if (sum_s4 < -lim) begin
			clamped = -lim;
		end else begin
			clamped = sum_s4;
		end
		q_clamp = clamped[Q_W-1:0];
		q_round = q_clamp + (q_clamp[Q_W-1] ? Q_W'(255) : Q_W'(0));
	end

	assign drive_fin = q_round[Q_W-1 -: DRIVE_W];
	assign wr_word   = {integ_s2, e_s1, older_s2, drive_fin};

endmodule

[hdl/multichannel_pid_speed_control_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_pid_speed_control_core
// per-channel positional or incremental pid speed controller
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result appears
// on out_channel and drive with done high for one cycle, and a new request
// can be taken once busy is low again: the channel state makes one
// read-modify-write trip through the state memory, operand select, gain
// multiply, sum and clamp steps. The receiver cannot stall the result.
// Channels at or above CHANNELS return a drive of zero and leave all state
// untouched. The user must write configuration via cfg_we, cfg_index and
// cfg_data only while the core is idle; the core does not enforce this.
// ----------------------------------------------------------------------------
module multichannel_pid_speed_control_core import mpsc_pkg::*; #(
	parameter int CHANNELS   = CHANNELS_DEF,
	parameter int INTEGRAL_W = INTEGRAL_W_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	input  logic                         start,
	output logic                         busy,
	input  logic [CHAN_W-1:0]            channel,
	input  logic signed [RPM_W-1:0]      target_rpm,
	input  logic signed [RPM_W-1:0]      measured_rpm,
	output logic                         done,
	output logic [CHAN_W-1:0]            out_channel,
	output logic signed [DRIVE_W-1:0]    drive
);

	localparam int AW     = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
	localparam int EXT_W  = AW > CHAN_W ? AW : CHAN_W;
	localparam int WORD_W = INTEGRAL_W + 2 * ERR_W + DRIVE_W;

	pid_state_t state_q, state_d;
	pid_cfg_t   cfg_q;
	dp_ctrl_t   ctrl;

	logic                      accept;
	logic                      in_range;
	logic [EXT_W-1:0]          chan_ext;
	logic [AW-1:0]             addr_q;
	logic [CHAN_W-1:0]         chan_q;
	logic                      in_range_q;
	logic                      mem_we;
	logic [WORD_W-1:0]         rd_word;
	logic [WORD_W-1:0]         wr_word;
	logic signed [DRIVE_W-1:0] drive_fin;
	logic                      done_q;
	logic [CHAN_W-1:0]         out_channel_q;
	logic signed [DRIVE_W-1:0] drive_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= PROP_GAIN_RST;
			cfg_q.integ_gain  <= INTEG_GAIN_RST;
			cfg_q.deriv_gain  <= DERIV_GAIN_RST;
			cfg_q.drive_limit <= DRIVE_LIMIT_RST;
			cfg_q.law_mode    <= LAW_POSITIONAL;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:  cfg_q.deriv_gain  <= cfg_data[GAIN_W-1:0];
				REG_DRIVE_LIMIT: cfg_q.drive_limit <= cfg_data[LIMIT_W-1:0];
				REG_LAW_MODE:    cfg_q.law_mode    <= law_t'(cfg_data[0]);
				default: ;
			endcase
		end
	end

	assign accept   = start && (state_q == ST_IDLE);
	assign chan_ext = EXT_W'(channel);
	assign in_range = 32'(channel) < CHANNELS;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		ctrl      = '0;
		busy      = 1'b1;
		mem_we    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy      = 1'b0;
				ctrl.load = start;
				if (start) begin
					state_d = ST_CALC;
				end
			end
			ST_CALC: begin
				ctrl.calc = 1'b1;
				state_d   = ST_MUL;
			end
			ST_MUL: begin
				ctrl.mul = 1'b1;
				state_d  = ST_SUM;
			end
			ST_SUM: begin
				ctrl.sum = 1'b1;
				state_d  = ST_FIN;
			end
			ST_FIN: begin
				mem_we  = in_range_q;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= chan_ext[AW-1:0];
			chan_q <= channel;
		end
		if (state_q == ST_FIN) begin
			out_channel_q <= chan_q;
			drive_q       <= in_range_q ? drive_fin : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_range_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			if (accept) begin
				in_range_q <= in_range;
			end
			done_q <= (state_q == ST_FIN);
		end
	end

	mpsc_state_mem #(
		.DEPTH  (CHANNELS),
		.WORD_W (WORD_W)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (accept),
		.raddr  (chan_ext[AW-1:0]),
		.rdata  (rd_word),
		.we     (mem_we),
		.waddr  (addr_q),
		.wdata  (wr_word)
	);

	mpsc_datapath #(
		.INTEGRAL_W (INTEGRAL_W)
	) u_dp (
		.clk          (clk),
		.ctrl         (ctrl),
		.cfg          (cfg_q),
		.target_rpm   (target_rpm),
		.measured_rpm (measured_rpm),
		.rd_word      (rd_word),
		.wr_word      (wr_word),
		.drive_fin    (drive_fin)
	);

	assign done        = done_q;
	assign out_channel = out_channel_q;
	assign drive       = drive_q;

	// every request is followed by a result strobe
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("result missing after request");

	a_done_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FIN))
		else $error("result strobe without final step");

	a_drive_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((drive <= $signed({1'b0, cfg_q.drive_limit}))
			&& (drive >= -$signed({1'b0, cfg_q.drive_limit}))))
		else $error("drive beyond limit");

	a_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (32'(out_channel) >= CHANNELS)) |-> (drive == '0))
		else $error("drive not zero for absent channel");

	a_write_once: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> !mem_we)
		else $error("state written twice for one request");

endmodule
